@@ rtl/core/tvmc_pkg.sv @@
package tvmc_pkg;

    localparam int CW   = 24;             // component width
    localparam int FB   = 16;             // fraction bits, shared by limits and components
    localparam int LW   = CW - 1;         // limit width
    localparam int GB   = 31 - CW;        // guard bits of the root
    localparam int SQW  = 2 * CW - 1;     // one square
    localparam int SUMW = 2 * CW;         // sum of three squares
    localparam int VW   = SUMW + 2 * GB;  // radicand
    localparam int RW   = CW + GB;        // root and divisor
    localparam int NUMW = SQW + GB;       // dividend
    localparam int QW   = LW;             // quotient

    localparam logic [LW-1:0] LIMIT_RESET = LW'(32'd1 << FB);

    localparam logic CFG_LINEAR  = 1'b0;
    localparam logic CFG_ANGULAR = 1'b1;

    typedef logic [CW-1:0] t_comp;

    typedef struct packed {
        t_comp [2:0]   raw;
        logic  [2:0]   neg;
        t_comp [2:0]   mag;
        logic [LW-1:0] lim;
        logic          clamp;
    } t_side;

endpackage

@@ rtl/core/tvmc_if.sv @@
interface tvmc_cmd_if import tvmc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] lin_x;
    logic signed [CW-1:0] lin_y;
    logic signed [CW-1:0] lin_z;
    logic signed [CW-1:0] ang_x;
    logic signed [CW-1:0] ang_y;
    logic signed [CW-1:0] ang_z;

    modport source (output valid, lin_x, lin_y, lin_z, ang_x, ang_y, ang_z, input ready);
    modport sink (input valid, lin_x, lin_y, lin_z, ang_x, ang_y, ang_z, output ready);
endinterface

interface tvmc_res_if import tvmc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] out_lin_x;
    logic signed [CW-1:0] out_lin_y;
    logic signed [CW-1:0] out_lin_z;
    logic signed [CW-1:0] out_ang_x;
    logic signed [CW-1:0] out_ang_y;
    logic signed [CW-1:0] out_ang_z;
    logic                 linear_clamped;
    logic                 angular_clamped;

    modport source (output valid, out_lin_x, out_lin_y, out_lin_z, out_ang_x, out_ang_y,
                    out_ang_z, linear_clamped, angular_clamped, input ready);
    modport sink (input valid, out_lin_x, out_lin_y, out_lin_z, out_ang_x, out_ang_y,
                  out_ang_z, linear_clamped, angular_clamped, output ready);
endinterface

@@ rtl/core/twist_velocity_magnitude_clamp.sv @@
// throughput: one command word per cycle; the root chain (31 cells) and the
// divide chain (23 cells) advance together, stalling only when the result waits
// reset (synchronous, active low): pipeline empties, both limits return to 1.0
module twist_velocity_magnitude_clamp import tvmc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tvmc_cmd_if.sink     i_cmd,
    tvmc_res_if.source   o_res,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    logic [LW-1:0] r_lin_limit, r_ang_limit;
    logic          en;
    logic          lin_valid, ang_valid;
    t_comp [2:0]   lin_res, ang_res;
    logic          lin_clamp, ang_clamp;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin_limit <= LIMIT_RESET;
            r_ang_limit <= LIMIT_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                CFG_LINEAR:  r_lin_limit <= pwdata[LW-1:0];
                CFG_ANGULAR: r_ang_limit <= pwdata[LW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            CFG_LINEAR:  prdata = {{(32-LW){1'b0}}, r_lin_limit};
            CFG_ANGULAR: prdata = {{(32-LW){1'b0}}, r_ang_limit};
            default:     prdata = '0;
        endcase
    end

    // the whole chain moves unless a finished word is held at the output
    assign en          = !lin_valid || o_res.ready;
    assign i_cmd.ready = en;

    tvmc_lane u_lin (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (i_cmd.valid),
        .i_raw     ({i_cmd.lin_z, i_cmd.lin_y, i_cmd.lin_x}),
        .i_lim     (r_lin_limit),
        .o_valid   (lin_valid),
        .o_res     (lin_res),
        .o_clamped (lin_clamp)
    );

    tvmc_lane u_ang (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (i_cmd.valid),
        .i_raw     ({i_cmd.ang_z, i_cmd.ang_y, i_cmd.ang_x}),
        .i_lim     (r_ang_limit),
        .o_valid   (ang_valid),
        .o_res     (ang_res),
        .o_clamped (ang_clamp)
    );

    // both lanes run in lockstep
    assign o_res.valid           = lin_valid && ang_valid;
    assign o_res.out_lin_x       = lin_res[0];
    assign o_res.out_lin_y       = lin_res[1];
    assign o_res.out_lin_z       = lin_res[2];
    assign o_res.out_ang_x       = ang_res[0];
    assign o_res.out_ang_y       = ang_res[1];
    assign o_res.out_ang_z       = ang_res[2];
    assign o_res.linear_clamped  = lin_clamp;
    assign o_res.angular_clamped = ang_clamp;
endmodule

@@ rtl/core/tvmc_sqrt_cell.sv @@
module tvmc_sqrt_cell import tvmc_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  t_side         i_side,
    input  logic [VW-1:0] i_v,
    input  logic [VW:0]   i_r,
    input  logic [VW-1:0] i_bit,
    output logic          o_valid,
    output t_side         o_side,
    output logic [VW-1:0] o_v,
    output logic [VW:0]   o_r
);
    logic          r_valid;
    t_side         r_side;
    logic [VW-1:0] r_v, n_v;
    logic [VW:0]   r_r, n_r;
    logic [VW:0]   rb;

    // one digit of the shift-and-subtract root
    always_comb begin
        rb = i_r + {1'b0, i_bit};
        if ({1'b0, i_v} >= rb) begin
            n_v = i_v - rb[VW-1:0];
            n_r = (i_r >> 1) + {1'b0, i_bit};
        end else begin
            n_v = i_v;
            n_r = i_r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_side <= i_side;
            r_v    <= n_v;
            r_r    <= n_r;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_v     = r_v;
    assign o_r     = r_r;
endmodule

@@ rtl/core/tvmc_div_cell.sv @@
module tvmc_div_cell import tvmc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  t_side               i_side,
    input  logic [RW-1:0]       i_d,
    input  logic [2:0][RW-1:0]  i_rem,
    input  logic [2:0][QW-1:0]  i_lo,
    input  logic [2:0][QW-1:0]  i_q,
    output logic                o_valid,
    output t_side               o_side,
    output logic [RW-1:0]       o_d,
    output logic [2:0][RW-1:0]  o_rem,
    output logic [2:0][QW-1:0]  o_lo,
    output logic [2:0][QW-1:0]  o_q
);
    logic               r_valid;
    t_side              r_side;
    logic [RW-1:0]      r_d;
    logic [2:0][RW-1:0] r_rem, n_rem;
    logic [2:0][QW-1:0] r_lo, n_lo;
    logic [2:0][QW-1:0] r_q, n_q;
    logic [2:0][RW:0]   t;

    // one quotient bit for each of the three components
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            t[k]     = {i_rem[k], i_lo[k][QW-1]};
            n_lo[k]  = i_lo[k] << 1;
            if (t[k] >= {1'b0, i_d}) begin
                n_rem[k] = RW'(t[k] - {1'b0, i_d});
                n_q[k]   = {i_q[k][QW-2:0], 1'b1};
            end else begin
                n_rem[k] = t[k][RW-1:0];
                n_q[k]   = {i_q[k][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_side <= i_side;
            r_d    <= i_d;
            r_rem  <= n_rem;
            r_lo   <= n_lo;
            r_q    <= n_q;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_d     = r_d;
    assign o_rem   = r_rem;
    assign o_lo    = r_lo;
    assign o_q     = r_q;
endmodule

@@ rtl/core/tvmc_lane.sv @@
module tvmc_lane import tvmc_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  t_comp [2:0]   i_raw,
    input  logic [LW-1:0] i_lim,
    output logic          o_valid,
    output t_comp [2:0]   o_res,
    output logic          o_clamped
);
    // square stage
    logic                r_a_valid;
    t_side               r_a_side, n_a_side;
    logic [2:0][SQW-1:0] r_a_sq;
    logic [2*LW-1:0]     r_a_limsq;
    // sum and compare stage
    logic                r_b_valid;
    t_side               r_b_side, n_b_side;
    logic [VW-1:0]       r_b_v;
    logic [SUMW-1:0]     sum;
    // root chain
    logic [RW:0]         c_valid;
    t_side [RW:0]        c_side;
    logic [RW:0][VW-1:0] c_v;
    logic [RW:0][VW:0]   c_r;
    // dividend stage
    logic                r_n_valid;
    t_side               r_n_side;
    logic [RW-1:0]       r_n_d;
    logic [2:0][RW-1:0]  r_n_rem;
    logic [2:0][QW-1:0]  r_n_lo;
    logic [2:0][NUMW-1:0] num;
    // divide chain
    logic [QW:0]              d_valid;
    t_side [QW:0]             d_side;
    logic [QW:0][RW-1:0]      d_d;
    logic [QW:0][2:0][RW-1:0] d_rem;
    logic [QW:0][2:0][QW-1:0] d_lo;
    logic [QW:0][2:0][QW-1:0] d_q;
    // result stage
    logic                r_o_valid;
    t_comp [2:0]         r_o_res, n_o_res;
    logic                r_o_clamp;

    always_comb begin
        n_a_side       = '0;
        n_a_side.raw   = i_raw;
        n_a_side.lim   = i_lim;
        for (int k = 0; k < 3; k++) begin
            n_a_side.neg[k] = i_raw[k][CW-1];
            n_a_side.mag[k] = i_raw[k][CW-1] ? CW'(-i_raw[k]) : i_raw[k];
        end
        sum = SUMW'(r_a_sq[0]) + SUMW'(r_a_sq[1]) + SUMW'(r_a_sq[2]);
        n_b_side       = r_a_side;
        n_b_side.clamp = sum > SUMW'(r_a_limsq);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
        if (i_en) begin
            r_a_side  <= n_a_side;
            for (int k = 0; k < 3; k++) begin
                r_a_sq[k] <= SQW'(n_a_side.mag[k] * n_a_side.mag[k]);
            end
            r_a_limsq <= i_lim * i_lim;
            r_b_side  <= n_b_side;
            r_b_v     <= {sum, {(2*GB){1'b0}}};
        end
    end

    assign c_valid[0] = r_b_valid;
    assign c_side[0]  = r_b_side;
    assign c_v[0]     = r_b_v;
    assign c_r[0]     = '0;

    for (genvar g = 0; g < RW; g++) begin : g_sqrt
        tvmc_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (c_valid[g]),
            .i_side  (c_side[g]),
            .i_v     (c_v[g]),
            .i_r     (c_r[g]),
            .i_bit   ({{(VW-1){1'b0}}, 1'b1} << (2 * (RW - 1 - g))),
            .o_valid (c_valid[g+1]),
            .o_side  (c_side[g+1]),
            .o_v     (c_v[g+1]),
            .o_r     (c_r[g+1])
        );
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            num[k] = {SQW'(c_side[RW].mag[k] * c_side[RW].lim), {GB{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_valid <= 1'b0;
        end else if (i_en) begin
            r_n_valid <= c_valid[RW];
        end
        if (i_en) begin
            r_n_side <= c_side[RW];
            r_n_d    <= c_r[RW][RW-1:0];
            for (int k = 0; k < 3; k++) begin
                r_n_rem[k] <= num[k][NUMW-1:QW];
                r_n_lo[k]  <= num[k][QW-1:0];
            end
        end
    end

    assign d_valid[0] = r_n_valid;
    assign d_side[0]  = r_n_side;
    assign d_d[0]     = r_n_d;
    assign d_rem[0]   = r_n_rem;
    assign d_lo[0]    = r_n_lo;
    assign d_q[0]     = '0;

    for (genvar g = 0; g < QW; g++) begin : g_div
        tvmc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (d_valid[g]),
            .i_side  (d_side[g]),
            .i_d     (d_d[g]),
            .i_rem   (d_rem[g]),
            .i_lo    (d_lo[g]),
            .i_q     (d_q[g]),
            .o_valid (d_valid[g+1]),
            .o_side  (d_side[g+1]),
            .o_d     (d_d[g+1]),
            .o_rem   (d_rem[g+1]),
            .o_lo    (d_lo[g+1]),
            .o_q     (d_q[g+1])
        );
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (!d_side[QW].clamp) begin
                n_o_res[k] = d_side[QW].raw[k];
            end else if (d_side[QW].neg[k]) begin
                n_o_res[k] = CW'(-{1'b0, d_q[QW][k]});
            end else begin
                n_o_res[k] = {1'b0, d_q[QW][k]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_en) begin
            r_o_valid <= d_valid[QW];
        end
        if (i_en) begin
            r_o_res   <= n_o_res;
            r_o_clamp <= d_side[QW].clamp;
        end
    end

    assign o_valid   = r_o_valid;
    assign o_res     = r_o_res;
    assign o_clamped = r_o_clamp;
endmodule

@@ rtl/core/tvmc_checker.sv @@
module tvmc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_lin_clamped
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    a_ready_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("input stalled while output drains");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word after reset");

    a_flag_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_lin_clamped))
        else $error("clamp flag changed while stalled");

    logic unused_in_valid;
    assign unused_in_valid = i_in_valid;
endmodule

bind twist_velocity_magnitude_clamp tvmc_checker u_tvmc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_cmd.valid),
    .i_in_ready    (i_cmd.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_lin_clamped (o_res.linear_clamped)
);

@@ tb/twist_velocity_magnitude_clamp_tb.sv @@
module twist_velocity_magnitude_clamp_tb;
    import tvmc_pkg::*;

    typedef struct packed {
        t_comp lx, ly, lz, ax, ay, az;
    } t_cmd_word;

    typedef struct packed {
        t_comp lx, ly, lz, ax, ay, az;
        logic  lin_clamp;
        logic  ang_clamp;
    } t_res_word;

    localparam int LATENCY   = 58;
    localparam int WD_LIMIT  = 20000;
    localparam int N_RANDOM  = 1200;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;

    tvmc_cmd_if cmd_bus();
    tvmc_res_if res_bus();

    twist_velocity_magnitude_clamp u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_bus.sink),
        .o_res  (res_bus.source),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    // predictor copy of the limit registers
    logic [LW-1:0] lin_limit_q;
    logic [LW-1:0] ang_limit_q;

    t_cmd_word pending_cmds[$];
    t_res_word expected_words[$];
    int  n_accepted;
    int  n_fail;
    int  idle_cycles;
    bit  cmd_burst_on;
    bit  cmd_taken;
    int  burst_left;
    logic [7:0] stall_lfsr;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r, b, x;
        r = 0;
        x = v;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic void clamp_vec(input t_comp c0, c1, c2, input logic [LW-1:0] lim,
                                      output t_comp r0, r1, r2, output logic clamped);
        t_comp       comps[3];
        t_comp       outs[3];
        logic [63:0] mag[3];
        logic        neg[3];
        logic [63:0] sum, root, q, l64;
        comps[0] = c0; comps[1] = c1; comps[2] = c2;
        sum = 0;
        l64 = lim;
        for (int i = 0; i < 3; i++) begin
            neg[i] = comps[i][CW-1];
            mag[i] = neg[i] ? 64'(t_comp'(-comps[i])) : 64'(comps[i]);
            // most negative value negates to itself: magnitude 2^23
            if (neg[i] && comps[i] == {1'b1, {(CW-1){1'b0}}}) mag[i] = 64'd1 << (CW-1);
            sum += mag[i] * mag[i];
        end
        if (sum <= l64 * l64) begin
            outs = comps;
            clamped = 1'b0;
        end else begin
            root = int_sqrt(sum << (2 * GB));
            for (int i = 0; i < 3; i++) begin
                q = ((mag[i] * l64) << GB) / root;
                outs[i] = neg[i] ? t_comp'(-q) : t_comp'(q);
            end
            clamped = 1'b1;
        end
        r0 = outs[0]; r1 = outs[1]; r2 = outs[2];
    endfunction

    function automatic t_res_word predict_clamp(input t_cmd_word c);
        t_res_word r;
        clamp_vec(c.lx, c.ly, c.lz, lin_limit_q, r.lx, r.ly, r.lz, r.lin_clamp);
        clamp_vec(c.ax, c.ay, c.az, ang_limit_q, r.ax, r.ay, r.az, r.ang_clamp);
        return r;
    endfunction

    // whether the word on the bus was taken at the last rising edge
    always @(posedge i_clk) begin
        cmd_taken <= cmd_bus.valid && cmd_bus.ready;
    end

    // driver: bursts with random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cmd_bus.valid <= 1'b0;
        end else if (cmd_bus.valid && !cmd_taken) begin
            // hold the word
        end else begin
            if (burst_left == 0) begin
                cmd_burst_on = !cmd_burst_on;
                burst_left = cmd_burst_on ? $urandom_range(1, 30) : $urandom_range(0, 6);
                if ($urandom_range(0, 9) == 0) burst_left = 0;
            end
            if (burst_left > 0) burst_left--;
            if (cmd_burst_on && pending_cmds.size() > 0) begin
                t_cmd_word w;
                w = pending_cmds.pop_front();
                cmd_bus.valid <= 1'b1;
                {cmd_bus.lin_x, cmd_bus.lin_y, cmd_bus.lin_z,
                 cmd_bus.ang_x, cmd_bus.ang_y, cmd_bus.ang_z} <= w;
            end else begin
                cmd_bus.valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern from a small lfsr, with stall-free stretches
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            stall_lfsr <= 8'hA5;
            res_bus.ready <= 1'b0;
        end else begin
            stall_lfsr <= {stall_lfsr[6:0], stall_lfsr[7] ^ stall_lfsr[5] ^ stall_lfsr[4]
                           ^ stall_lfsr[3]};
            res_bus.ready <= stall_lfsr[7] ? 1'b1 : (stall_lfsr[2:0] != 3'b000);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cmd_bus.valid && cmd_bus.ready) begin
                expected_words.push_back(predict_clamp({cmd_bus.lin_x, cmd_bus.lin_y,
                    cmd_bus.lin_z, cmd_bus.ang_x, cmd_bus.ang_y, cmd_bus.ang_z}));
                n_accepted++;
            end
            if (res_bus.valid && res_bus.ready) begin
                if (expected_words.size() == 0) begin
                    $error("result word with no command pending");
                    n_fail++;
                end else begin
                    t_res_word e;
                    e = expected_words.pop_front();
                    if (res_bus.out_lin_x !== e.lx) begin
                        $error("out_lin_x exp %0d got %0d", $signed(e.lx), res_bus.out_lin_x);
                        n_fail++;
                    end
                    if (res_bus.out_lin_y !== e.ly) begin
                        $error("out_lin_y exp %0d got %0d", $signed(e.ly), res_bus.out_lin_y);
                        n_fail++;
                    end
                    if (res_bus.out_lin_z !== e.lz) begin
                        $error("out_lin_z exp %0d got %0d", $signed(e.lz), res_bus.out_lin_z);
                        n_fail++;
                    end
                    if (res_bus.out_ang_x !== e.ax) begin
                        $error("out_ang_x exp %0d got %0d", $signed(e.ax), res_bus.out_ang_x);
                        n_fail++;
                    end
                    if (res_bus.out_ang_y !== e.ay) begin
                        $error("out_ang_y exp %0d got %0d", $signed(e.ay), res_bus.out_ang_y);
                        n_fail++;
                    end
                    if (res_bus.out_ang_z !== e.az) begin
                        $error("out_ang_z exp %0d got %0d", $signed(e.az), res_bus.out_ang_z);
                        n_fail++;
                    end
                    if (res_bus.linear_clamped !== e.lin_clamp) begin
                        $error("linear_clamped exp %0b got %0b", e.lin_clamp,
                               res_bus.linear_clamped);
                        n_fail++;
                    end
                    if (res_bus.angular_clamped !== e.ang_clamp) begin
                        $error("angular_clamped exp %0b got %0b", e.ang_clamp,
                               res_bus.angular_clamped);
                        n_fail++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready)
            || expected_words.size() == 0 && pending_cmds.size() == 0) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WD_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic write_limit(input logic idx, input logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 3'(idx) << 2;
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (idx == CFG_LINEAR) lin_limit_q = value[LW-1:0];
        else ang_limit_q = value[LW-1:0];
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic drain();
        while (pending_cmds.size() > 0 || expected_words.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic t_comp rand_comp(input int scale);
        t_comp v;
        case ($urandom_range(0, 9))
            0: v = {1'b1, {(CW-1){1'b0}}};
            1: v = {1'b0, {(CW-1){1'b1}}};
            2: v = '0;
            default: begin
                v = t_comp'($urandom);
                v = t_comp'($signed(v) >>> $urandom_range(0, scale));
            end
        endcase
        return v;
    endfunction

    task automatic push_random(input int count);
        t_cmd_word w;
        int sc;
        for (int i = 0; i < count; i++) begin
            sc = $urandom_range(0, CW - 2);
            w = {rand_comp(sc), rand_comp(sc), rand_comp(sc),
                 rand_comp(sc), rand_comp(sc), rand_comp(sc)};
            if ($urandom_range(0, 7) == 0) {w.lx, w.ly, w.lz} = '0;
            if ($urandom_range(0, 7) == 0) {w.ax, w.ay, w.az} = '0;
            pending_cmds.push_back(w);
        end
    endtask

    initial begin
        t_comp mn, mx, one;
        mn = {1'b1, {(CW-1){1'b0}}};
        mx = {1'b0, {(CW-1){1'b1}}};
        one = t_comp'(32'd1 << FB);
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        cmd_bus.valid = 1'b0;
        {cmd_bus.lin_x, cmd_bus.lin_y, cmd_bus.lin_z,
         cmd_bus.ang_x, cmd_bus.ang_y, cmd_bus.ang_z} = '0;
        res_bus.ready = 1'b0;
        lin_limit_q = LIMIT_RESET;
        ang_limit_q = LIMIT_RESET;
        n_accepted = 0; n_fail = 0; idle_cycles = 0;
        cmd_burst_on = 1'b0; burst_left = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed words at reset limits
        pending_cmds.push_back('0);
        pending_cmds.push_back({mx, mx, mx, mn, mn, mn});
        pending_cmds.push_back({mn, t_comp'(0), t_comp'(0), mx, t_comp'(0), t_comp'(0)});
        pending_cmds.push_back({one, t_comp'(0), t_comp'(0), t_comp'(-one), t_comp'(0),
                                t_comp'(0)});
        pending_cmds.push_back({one, t_comp'(1), t_comp'(0), t_comp'(1), t_comp'(-1),
                                t_comp'(1)});
        pending_cmds.push_back({t_comp'(-1), t_comp'(-1), t_comp'(-1), mx, mn, mx});
        pending_cmds.push_back({t_comp'(24'h5555AA), t_comp'(24'hAAAA55), t_comp'(1),
                                t_comp'(24'h0F0F0F), t_comp'(24'hF0F0F0), t_comp'(-2)});
        drain();

        // zero limits
        write_limit(CFG_LINEAR, 32'd0);
        write_limit(CFG_ANGULAR, 32'd0);
        pending_cmds.push_back('0);
        pending_cmds.push_back({t_comp'(1), t_comp'(0), t_comp'(0), mn, mx, t_comp'(-1)});
        push_random(6);
        drain();

        // largest limits, wider value is truncated
        write_limit(CFG_LINEAR, 32'hFFFF_FFFF);
        write_limit(CFG_ANGULAR, 32'h007F_FFFF);
        pending_cmds.push_back({mx, mx, mx, mn, mn, mn});
        pending_cmds.push_back({mn, t_comp'(0), t_comp'(0), mx, t_comp'(0), t_comp'(0)});
        push_random(4);
        drain();

        // random phases with random limits
        for (int ph = 0; ph < 6; ph++) begin
            write_limit(CFG_LINEAR, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 400000));
            write_limit(CFG_ANGULAR, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 400000));
            push_random(N_RANDOM / 6);
            drain();
        end

        if (n_fail == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/tvmc_pkg.sv
rtl/core/tvmc_if.sv
rtl/core/tvmc_sqrt_cell.sv
rtl/core/tvmc_div_cell.sv
rtl/core/tvmc_lane.sv
rtl/core/twist_velocity_magnitude_clamp.sv
rtl/core/tvmc_checker.sv
tb/twist_velocity_magnitude_clamp_tb.sv
